[hw/rtl/bdaf_pkg.sv]
// ----------------------------------------------------------------------------
// bdaf_pkg
// Shared constants for the binary to decimal ASCII formatter.
// ----------------------------------------------------------------------------
package bdaf_pkg;

  localparam int CHAR_W = 6;
  localparam int BCD_W  = 4;

  // ASCII codes, low six bits
  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CH_POINT = 6'd46;

  // add-3 threshold for the shift-and-add BCD conversion
  localparam logic [BCD_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [BCD_W-1:0] BCD_ADJ_ADD = 4'd3;

endpackage

[hw/rtl/bdaf_in_if.sv]
// ----------------------------------------------------------------------------
// bdaf_in_if
// Value channel: valid/ready with kind selector and raw value.
// ----------------------------------------------------------------------------
interface bdaf_in_if #(
  parameter int VALUE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

[hw/rtl/bdaf_out_if.sv]
// ----------------------------------------------------------------------------
// bdaf_out_if
// Character channel: valid/ready with ASCII code and last marker.
// ----------------------------------------------------------------------------
interface bdaf_out_if
  import bdaf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

[hw/rtl/binary_to_decimal_ascii_formatter.sv]
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_formatter
// Turns a binary value into decimal ASCII text, one character per word.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one word per value, kind (0 unsigned, 1 signed tenths) + value.
//   out_ch : the text, most significant character first, last marks the end.
//   Kind 0 prints without leading zeros ("0" for zero). Kind 1 prints an
//   optional '-', the integer part ("0" if empty), '.', and the tenths digit.
// Timing:
//   One value at a time; in_ch.ready is high only while idle.
//   A shared shift-and-add-3 BCD unit runs over the VALUE_BITS bits, a
//   leading-zero skip steps over the zero digits, then one character per
//   cycle while out_ch.ready does not stall the output.
// Stall:
//   Characters sit in one output register; while one waits and out_ch.ready
//   is low, the sequencer holds before the next character. The next value is
//   taken as soon as the final character is loaded, even if it still waits.
// Reset:
//   Synchronous, active low; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_formatter
  import bdaf_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  bdaf_in_if.sink     in_ch,
  bdaf_out_if.source  out_ch
);

  localparam int NDIG  = (VALUE_BITS * 301) / 1000 + 1;
  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam int IDX_W = $clog2(NDIG);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_SKIP  = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;
  localparam logic [2:0] ST_POINT = 3'd5;
  localparam logic [2:0] ST_TENTH = 3'd6;

  logic [2:0]                  state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]           char_r, char_nxt;
  logic                        last_r, last_nxt;
  logic                        kind_r, kind_nxt;
  logic                        neg_r, neg_nxt;
  logic [VALUE_BITS-1:0]       sh_r, sh_nxt;
  logic [NDIG-1:0][BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;

  logic [NDIG-1:0][BCD_W-1:0]  adj;
  logic [NDIG*BCD_W:0]         shifted;
  logic [IDX_W-1:0]            idx_low;
  logic [BCD_W-1:0]            cur_dig;
  logic [CHAR_W-1:0]           cur_char;
  logic                        emit_ok;
  logic                        in_neg;

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = char_r;
  assign out_ch.last      = last_r;

  assign emit_ok  = !out_valid_r || out_ch.ready;
  assign idx_low  = {{(IDX_W-1){1'b0}}, kind_r};
  assign cur_dig  = bcd_r[idx_r];
  assign cur_char = CH_ZERO + {{(CHAR_W-BCD_W){1'b0}}, cur_dig};
  assign in_neg   = in_ch.kind && in_ch.value[VALUE_BITS-1];

  // add-3 on every BCD digit, then shift one bit in
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = (bcd_r[i] >= BCD_ADJ_MIN) ? (bcd_r[i] + BCD_ADJ_ADD) : bcd_r[i];
    end
    shifted = {adj, sh_r[VALUE_BITS-1]};
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    char_nxt      = char_r;
    last_nxt      = last_r;
    kind_nxt      = kind_r;
    neg_nxt       = neg_r;
    sh_nxt        = sh_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt  = in_ch.kind;
          neg_nxt   = in_neg;
          sh_nxt    = in_neg ? ({VALUE_BITS{1'b0}} - in_ch.value) : in_ch.value;
          bcd_nxt   = '0;
          cnt_nxt   = CNT_W'(VALUE_BITS - 1);
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = shifted[NDIG*BCD_W-1:0];
        sh_nxt  = {sh_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          idx_nxt   = IDX_W'(NDIG - 1);
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (idx_r != idx_low && cur_dig == '0) begin
          idx_nxt = idx_r - 1'b1;
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          char_nxt      = CH_MINUS;
          last_nxt      = 1'b0;
          state_nxt     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          char_nxt      = cur_char;
          last_nxt      = !kind_r && (idx_r == idx_low);
          if (idx_r == idx_low) begin
            state_nxt = kind_r ? ST_POINT : ST_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      ST_POINT: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          char_nxt      = CH_POINT;
          last_nxt      = 1'b0;
          idx_nxt       = '0;
          state_nxt     = ST_TENTH;
        end
      end
      ST_TENTH: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          char_nxt      = cur_char;
          last_nxt      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
    kind_r <= kind_nxt;
    neg_r  <= neg_nxt;
    sh_r   <= sh_nxt;
    bcd_r  <= bcd_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
  end

endmodule

[hw/rtl/bdaf_chk.sv]
// ----------------------------------------------------------------------------
// bdaf_chk
// Port-level checks for the decimal ASCII formatter, bound to the top level.
// ----------------------------------------------------------------------------
module bdaf_chk
  import bdaf_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_character,
  input logic              out_last
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("output word changed while stalled");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == CH_MINUS || out_character == CH_POINT ||
                   (out_character >= CH_ZERO && out_character <= (CH_ZERO + 6'd9))))
    else $error("illegal character code");

  // busy after taking a value
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready while converting");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind binary_to_decimal_ascii_formatter bdaf_chk u_bdaf_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_character (out_ch.character),
  .out_last      (out_ch.last)
);
